// ----- design/mvm_pkg.sv -----
// Shared types and constants of the int8 matrix-vector multiply block.
`default_nettype none

package mvm_pkg;

  localparam int VALUE_W      = 8;
  localparam int VEC_INDEX_W  = 10;
  localparam int ROW_NUM_W    = 12;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 24;

  // Input word kinds, carried in tuser.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_MATRIX = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_LEN = 1'b1;

  // One matrix element on its way from the sequencer to the accumulator.
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic                      end_row;
    logic [ROW_NUM_W-1:0]      row_number;
    logic                      last_row;
  } op_t;

  // One finished row.
  typedef struct packed {
    logic                      last_row;
    logic [ROW_NUM_W-1:0]      row_number;
    logic signed [VALUE_W-1:0] row_sum;
  } res_t;

endpackage

`default_nettype wire

// ----- design/int8_matrix_vector_multiply.sv -----
// Top level of the streaming signed 8-bit matrix-vector multiply block.
//
// The block keeps a vector of signed 8-bit elements in an on-chip RAM of
// MAX_INNER entries and multiplies a streamed matrix against it. A word with
// tuser low loads one vector element at vec_index (indexes at or above
// MAX_INNER are dropped); a word with tuser high is the next matrix element
// in row-major order. Each element is multiplied by the vector element of the
// current column and added to an 8-bit accumulator that wraps modulo 256.
// After inner_len elements the block emits one word with the wrapped sum and
// the row number, and raises tlast on row row_count-1, after which the row
// number starts over at zero. Register values of zero act as one, and values
// above MAX_INNER or MAX_ROWS saturate; an inner_len write uses only
// cfg_data[10:0]. Vector entries must be loaded before a matrix element reads
// them; the RAM has no reset and no clearing pass. Input is taken at one word
// per clock cycle while s_axis_tready is high: the vector RAM is read once per
// matrix element, its registered read data meets the registered element in the
// multiply-accumulate, and each row result is written into a two-entry output
// queue that decouples the sink; input is held off only while that queue and
// the result in flight would fill it. Configuration writes are meant for idle
// periods; counters and the accumulator keep their values across them.
`default_nettype none

module int8_matrix_vector_multiply import mvm_pkg::*; #(
  parameter int MAX_INNER = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Configuration write port.
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  // Input stream.
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,   // vec_index[9:0], value[17:10]
  input  wire logic                    s_axis_tuser,   // command
  // Result stream.
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic      [OUT_TDATA_W-1:0]  m_axis_tdata,   // row_sum[7:0], row_number[19:8]
  output logic                         m_axis_tlast    // last_row
);

  localparam int AW = $clog2(MAX_INNER);

  logic               accept;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;
  op_t                op;
  logic               push;
  res_t               push_data;
  logic               pending;
  logic               pop;
  res_t               head;
  logic [1:0]         count;
  logic [2:0]         occupancy;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;

  // A word accepted now can push a result once it has passed the op register.
  // Accept only when the queue, after this edge, holds at most one entry.
  assign occupancy     = {1'b0, count} + {2'b0, pending};
  assign s_axis_tready = (occupancy <= 3'd1 + {2'b0, pop});

  mvm_seq #(
    .MAX_INNER (MAX_INNER),
    .MAX_ROWS  (MAX_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .command   (s_axis_tuser),
    .vec_index (s_axis_tdata[9:0]),
    .value     (s_axis_tdata[17:10]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .op        (op)
  );

  mvm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_INNER)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mvm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .vec       (ram_rdata),
    .push      (push),
    .push_data (push_data),
    .pending   (pending)
  );

  mvm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .valid     (m_axis_tvalid),
    .head      (head),
    .count     (count)
  );

  assign m_axis_tdata = {4'b0, head.row_number, head.row_sum};
  assign m_axis_tlast = head.last_row;

  // A full queue with nothing leaving must hold off the source.
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output queue is full");

endmodule

`default_nettype wire

// ----- design/mvm_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/mvm_seq.sv -----
// Sequencer: configuration registers, column and row counters, vector store access.
`default_nettype none

module mvm_seq import mvm_pkg::*; #(
  parameter int MAX_INNER = 1024,
  parameter int MAX_ROWS  = 4096,
  localparam int AW = $clog2(MAX_INNER),
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                         accept,
  input  wire logic                         command,
  input  wire logic [VEC_INDEX_W-1:0]       vec_index,
  input  wire logic signed [VALUE_W-1:0]    value,
  output logic                              ram_we,
  output logic      [AW-1:0]                ram_waddr,
  output logic      [VALUE_W-1:0]           ram_wdata,
  output logic                              ram_re,
  output logic      [AW-1:0]                ram_raddr,
  output op_t                               op
);

  logic [AW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] last_col;
  logic [RW-1:0] last_row_idx;
  logic          take_matrix;
  logic          end_row;
  logic          last;

  // Index of the last element for a length register; zero counts as one and
  // values above the hardware limit saturate.
  function automatic logic [31:0] last_index(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd0;
    end else if (v > hi) begin
      r = hi - 32'd1;
    end else begin
      r = v - 32'd1;
    end
    return r;
  endfunction

  assign take_matrix = accept && (command == CMD_MATRIX);
  assign end_row     = (col >= last_col);
  assign last        = (row >= last_row_idx);

  assign ram_we    = accept && (command == CMD_LOAD) && (32'(vec_index) < 32'(MAX_INNER));
  assign ram_waddr = AW'(vec_index);
  assign ram_wdata = value;
  assign ram_re    = take_matrix;
  assign ram_raddr = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      last_col     <= '0;
      last_row_idx <= '0;
      op           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_COUNT: last_row_idx <= RW'(last_index(32'(cfg_data), 32'(MAX_ROWS)));
          REG_INNER_LEN: last_col <= AW'(last_index(32'(cfg_data[10:0]), 32'(MAX_INNER)));
          default: ;
        endcase
      end
      op.valid      <= take_matrix;
      op.value      <= value;
      op.end_row    <= end_row;
      op.row_number <= ROW_NUM_W'(row);
      op.last_row   <= last;
      if (take_matrix) begin
        if (end_row) begin
          col <= '0;
          row <= last ? '0 : row + RW'(1);
        end else begin
          col <= col + AW'(1);
        end
      end
    end
  end

  a_col_wraps: assert property (@(posedge clk) disable iff (rst)
    take_matrix && end_row |=> col == '0)
    else $error("column counter did not restart at the end of a row");

endmodule

`default_nettype wire

// ----- design/mvm_mac.sv -----
// Multiply-accumulate stage: one product per matrix element into the row sum.
`default_nettype none

module mvm_mac import mvm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire op_t                op,
  input  wire logic [VALUE_W-1:0] vec,
  output logic                    push,
  output res_t                    push_data,
  output logic                    pending
);

  logic signed [VALUE_W-1:0]   acc;
  logic signed [2*VALUE_W-1:0] prod;
  logic        [VALUE_W-1:0]   sum;

  // Only the low byte of the product matters since the sum wraps mod 256.
  assign prod = op.value * $signed(vec);
  assign sum  = acc + prod[VALUE_W-1:0];

  assign pending = op.valid && op.end_row;
  assign push    = pending;

  assign push_data.row_sum    = sum;
  assign push_data.row_number = op.row_number;
  assign push_data.last_row   = op.last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (op.valid) begin
      acc <= op.end_row ? '0 : sum;
    end
  end

  a_acc_clears: assert property (@(posedge clk) disable iff (rst)
    op.valid && op.end_row |=> acc == '0)
    else $error("accumulator not cleared after a row");

endmodule

`default_nettype wire

// ----- design/mvm_outq.sv -----
// Two-entry output queue holding finished rows until the sink takes them.
`default_nettype none

module mvm_outq import mvm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire res_t       push_data,
  input  wire logic       pop,
  output logic            valid,
  output res_t            head,
  output logic [1:0]      count
);

  res_t slot1;

  assign valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (count == 2'd1)) begin
        head <= push_data;
      end else begin
        head <= slot1;
      end
      if (push && (count == 2'd2)) begin
        slot1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (count == 2'd2)))
    else $error("output queue overflow");

endmodule

`default_nettype wire
